@@ hw/rtl/i2cbb_pkg.sv @@
// Shared types and constants for the tick-driven I2C bit-bang master.
// No dependencies; compiled first.

package i2cbb_pkg;

  localparam int MODE_W   = 3;
  localparam int DATA_W   = 8;
  localparam int TICK_W   = 16;
  localparam int BITCNT_W = 4;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  localparam logic [TICK_W-1:0]   HALF_PERIOD_RESET = 16'd50;
  localparam logic [BITCNT_W-1:0] BITS_PER_BYTE     = 4'd8;

  // Mode codes on the command channel
  localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_START = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STOP  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WRITE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

  // Classified command carried through the queue
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ
  } cmd_t;

  // Bus waveform phases
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_A,
    PH_ST_B,
    PH_SP_A,
    PH_SP_B,
    PH_WR_SETUP,
    PH_WR_HIGH,
    PH_WA_LOW,
    PH_WA_HIGH,
    PH_RD_REL,
    PH_RD_HIGH,
    PH_RD_LOW,
    PH_RA_HIGH,
    PH_RA_LOW
  } phase_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [DATA_W-1:0] write_data;
    logic              ack_after_read;
    logic              sda_in;
  } item_t;

  // Head of the queue as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

@@ hw/rtl/i2cbb_cmd_if.sv @@
// Command channel: valid/ready handshake with one tick's command and SDA sample.
// Depends on i2cbb_pkg.

interface i2cbb_cmd_if;
  import i2cbb_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [DATA_W-1:0] write_data;
  logic              ack_after_read;
  logic              sda_in;

  modport source (output valid, mode, write_data, ack_after_read, sda_in, input ready);
  modport sink   (input valid, mode, write_data, ack_after_read, sda_in, output ready);
endinterface

@@ hw/rtl/i2cbb_res_if.sv @@
// Result channel: valid/ready handshake with the bus levels and status of one tick.
// Depends on i2cbb_pkg.

interface i2cbb_res_if;
  import i2cbb_pkg::*;

  logic              valid;
  logic              ready;
  logic              scl_out;
  logic              sda_out;
  logic              busy_res;
  logic              done_res;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, read_data, input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, read_data, output ready);
endinterface

@@ hw/rtl/i2cbb_front.sv @@
// Front end: accepts command beats and classifies the mode code.
// Depends on i2cbb_pkg and i2cbb_cmd_if.

module i2cbb_front (
  i2cbb_cmd_if.sink       cmd,
  input  logic            q_full,
  output logic            push,
  output i2cbb_pkg::item_t item
);
  import i2cbb_pkg::*;

  cmd_t cmd_class;

  // Unknown codes act as a plain tick
  always_comb begin
    unique case (cmd.mode)
      MODE_START: cmd_class = CMD_START;
      MODE_STOP:  cmd_class = CMD_STOP;
      MODE_WRITE: cmd_class = CMD_WRITE;
      MODE_READ:  cmd_class = CMD_READ;
      default:    cmd_class = CMD_NONE;
    endcase
  end

  assign cmd.ready = !q_full;
  assign push      = cmd.valid && !q_full;

  assign item.cmd            = cmd_class;
  assign item.write_data     = cmd.write_data;
  assign item.ack_after_read = cmd.ack_after_read;
  assign item.sda_in         = cmd.sda_in;

endmodule

@@ hw/rtl/i2cbb_queue.sv @@
// Short FIFO of classified beats between front and back end.
// Depends on i2cbb_pkg.

module i2cbb_queue #(
  parameter int DEPTH = i2cbb_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  i2cbb_pkg::item_t   push_item,
  output logic               full,
  input  logic               pop,
  output i2cbb_pkg::q_head_t head
);
  import i2cbb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t              slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_pop;

  assign full   = (count == CNT_W'(DEPTH));
  assign do_pop = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_pop_has_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty queue");
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");
`endif

endmodule

@@ hw/rtl/i2cbb_engine.sv @@
// Back end: runs the bus waveform one tick per queued beat and registers the result.
// Depends on i2cbb_pkg and i2cbb_res_if.

module i2cbb_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [i2cbb_pkg::TICK_W-1:0]    cfg_wdata,
  input  i2cbb_pkg::q_head_t              head,
  output logic                            pop,
  i2cbb_res_if.source                     res
);
  import i2cbb_pkg::*;

  logic [TICK_W-1:0]   half_period;
  phase_t              phase,       phase_next;
  logic [BITCNT_W-1:0] bit_count,   bit_count_next;
  logic [TICK_W-1:0]   wait_count,  wait_count_next;
  logic [DATA_W-1:0]   shift_reg,   shift_reg_next;
  logic                ack_choice,  ack_choice_next;
  logic                scl_level,   scl_level_next;
  logic                sda_level,   sda_level_next;
  logic [DATA_W-1:0]   read_byte,   read_byte_next;
  logic                finish;
  logic                step;
  logic                busy_next;
  logic                done_next;

  // Advance one tick whenever a beat waits and the result slot frees up
  assign step = head.valid && (!res.valid || res.ready);
  assign pop  = step;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RESET;
    end else if (cfg_we) begin
      half_period <= cfg_wdata;
    end
  end

  // Next state: launch a command from idle, then run the tick on the phase
  always_comb begin : next_state
    phase_t              ph;
    logic [BITCNT_W-1:0] bc;
    logic [TICK_W-1:0]   wc;
    logic [DATA_W-1:0]   sh;
    logic                ac;
    logic                scl;
    logic                sda;
    logic [DATA_W-1:0]   rb;
    logic                fin;

    ph  = phase;
    bc  = bit_count;
    wc  = wait_count;
    sh  = shift_reg;
    ac  = ack_choice;
    scl = scl_level;
    sda = sda_level;
    rb  = read_byte;
    fin = 1'b0;

    if (phase == PH_IDLE) begin
      bc = '0;
      unique case (head.item.cmd)
        CMD_START: begin
          ph = PH_ST_A; scl = 1'b1; sda = 1'b1; wc = half_period;
        end
        CMD_STOP: begin
          ph = PH_SP_A; scl = 1'b1; sda = 1'b0; wc = half_period;
        end
        CMD_WRITE: begin
          sh = head.item.write_data;
          ph = PH_WR_SETUP; scl = 1'b0; sda = head.item.write_data[DATA_W-1];
          wc = half_period;
        end
        CMD_READ: begin
          sh = '0;
          ac = head.item.ack_after_read;
          ph = PH_RD_REL; sda = 1'b1; wc = half_period;
        end
        default: begin
        end
      endcase
    end

    if (ph != PH_IDLE) begin
      if (wc > 16'd1) begin
        wc = wc - 16'd1;
      end else begin
        // every non-final phase reloads the wait counter on entry
        wc = half_period;
        unique case (ph)
          PH_ST_A: begin
            ph = PH_ST_B; scl = 1'b1; sda = 1'b0;
          end
          PH_ST_B: begin
            scl = 1'b0; fin = 1'b1;
          end
          PH_SP_A: begin
            ph = PH_SP_B; scl = 1'b1; sda = 1'b1;
          end
          PH_SP_B: begin
            fin = 1'b1;
          end
          PH_WR_SETUP: begin
            ph = PH_WR_HIGH; scl = 1'b1;
          end
          PH_WR_HIGH: begin
            sh = {sh[DATA_W-2:0], 1'b0};
            bc = bc + 1'b1;
            scl = 1'b0;
            if (bc >= BITS_PER_BYTE) begin
              ph = PH_WA_LOW; sda = 1'b1;
            end else begin
              ph = PH_WR_SETUP; sda = sh[DATA_W-1];
            end
          end
          PH_WA_LOW: begin
            ph = PH_WA_HIGH; scl = 1'b1; sda = 1'b1;
          end
          PH_WA_HIGH: begin
            scl = 1'b0; fin = 1'b1;
          end
          PH_RD_REL: begin
            ph = PH_RD_HIGH; scl = 1'b1; sda = 1'b1;
          end
          PH_RD_HIGH: begin
            sh = {sh[DATA_W-2:0], head.item.sda_in};
            bc = bc + 1'b1;
            ph = PH_RD_LOW; scl = 1'b0; sda = 1'b1;
          end
          PH_RD_LOW: begin
            scl = 1'b1;
            if (bc >= BITS_PER_BYTE) begin
              ph = PH_RA_HIGH; sda = !ac;
            end else begin
              ph = PH_RD_HIGH; sda = 1'b1;
            end
          end
          PH_RA_HIGH: begin
            ph = PH_RA_LOW; scl = 1'b0;
          end
          PH_RA_LOW: begin
            rb = sh; fin = 1'b1;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
        if (fin) begin
          ph = PH_IDLE;
          wc = '0;
        end
      end
    end

    phase_next      = ph;
    bit_count_next  = bc;
    wait_count_next = wc;
    shift_reg_next  = sh;
    ack_choice_next = ac;
    scl_level_next  = scl;
    sda_level_next  = sda;
    read_byte_next  = rb;
    finish          = fin;
  end

  // Outputs: status of the tick as it leaves this cycle
  always_comb begin : outputs
    busy_next = (phase_next != PH_IDLE);
    done_next = finish;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_count  <= '0;
      wait_count <= '0;
      shift_reg  <= '0;
      ack_choice <= 1'b0;
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
      read_byte  <= '0;
    end else if (step) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      wait_count <= wait_count_next;
      shift_reg  <= shift_reg_next;
      ack_choice <= ack_choice_next;
      scl_level  <= scl_level_next;
      sda_level  <= sda_level_next;
      read_byte  <= read_byte_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (step) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res.scl_out   <= scl_level_next;
      res.sda_out   <= sda_level_next;
      res.busy_res  <= busy_next;
      res.done_res  <= done_next;
      res.read_data <= read_byte_next;
    end
  end

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.done_res) |-> !res.busy_res)
    else $error("done reported while still busy");
  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= BITS_PER_BYTE)
    else $error("bit count past one byte");
  a_hold_without_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> ($stable(wait_count) && $stable(phase)))
    else $error("engine state moved without a tick");
  a_idle_wait_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (wait_count == '0))
    else $error("wait counter left loaded in idle");
`endif

endmodule

@@ hw/rtl/i2cbb_master_core.sv @@
// Top level of the tick-driven I2C bit-bang master: front end, queue, engine.
// Depends on i2cbb_pkg, i2cbb_cmd_if, i2cbb_res_if, i2cbb_front, i2cbb_queue, i2cbb_engine.
//
// Usage:
//   Each beat on the cmd channel is one tick of bus timing. It carries a mode
//   (tick only, start, stop, write byte, read byte), the byte to write, the
//   ACK/NACK choice for a read and the sampled SDA pin level. Commands are
//   only launched while the engine is idle; otherwise the mode is ignored.
//   Every cmd beat yields exactly one res beat with the SCL/SDA drive levels
//   (1 = released), busy, a one-tick done pulse and the last read byte.
//   User writes half_period through cfg_we/cfg_wdata while the block is idle; not enforced.
// Timing:
//   Throughput is one beat per clock while res is not stalled. From cmd accept
//   to res valid a beat passes through the queue slot and then the result
//   register. The engine evaluates one full tick per cycle while the result
//   slot is free.
// Reset (rst, synchronous): queue empties, result slot drops valid, phase
//   goes idle with both lines released, half_period returns to 50.
// Backpressure: while res is stalled the engine holds its state; the queue
//   absorbs up to QUEUE_DEPTH beats, then cmd.ready drops.

module i2c_bitbang_master_core #(
  parameter int QUEUE_DEPTH = i2cbb_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [i2cbb_pkg::TICK_W-1:0] cfg_wdata,
  i2cbb_cmd_if.sink                    cmd,
  i2cbb_res_if.source                  res
);
  import i2cbb_pkg::*;

  logic    q_full;
  logic    q_push;
  item_t   q_item;
  logic    q_pop;
  q_head_t q_head;

  // Classify the incoming beat and push it into the queue
  i2cbb_front u_front (
    .cmd    (cmd),
    .q_full (q_full),
    .push   (q_push),
    .item   (q_item)
  );

  // Decouple front from engine so a stalled result does not block input
  i2cbb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  // Run the bus waveform and hold each tick's result
  i2cbb_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (q_head),
    .pop       (q_pop),
    .res       (res)
  );

endmodule
